@@ hdl/rws_pkg.sv @@
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants of the roulette wheel selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

   localparam int MAX_POPULATION  = 64;
   localparam int FITNESS_BITS    = 32;
   localparam int DRAW_BITS       = 16;
   localparam int DRAW_FIELD_BITS = DRAW_BITS + 1;
   localparam int INDEX_BITS      = 6;
   localparam int SIZE_BITS       = 7;
   localparam int STATUS_BITS     = 2;
   localparam int SUM_BITS        = FITNESS_BITS + $clog2(MAX_POPULATION);
   localparam int PRODUCT_BITS    = SUM_BITS + DRAW_FIELD_BITS;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_TOTAL = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INCOMPLETE = 2'd2;

   typedef struct packed {
      logic                       kind;
      logic [FITNESS_BITS-1:0]    fitness_value;
      logic [DRAW_FIELD_BITS-1:0] draw_fraction;
   } request_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  selected_index;
      logic [STATUS_BITS-1:0] status;
   } response_type;

   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [INDEX_BITS-1:0] index;
   } token_type;

endpackage

`default_nettype wire

@@ hdl/roulette_wheel_selector.sv @@
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportional selection over a row of prefix-sum cells.
// ----------------------------------------------------------------------------
// A load transaction writes the next prefix sum, and loads can follow back to
// back. For a draw on a complete table with a nonzero total, the
// draw-times-total product is registered at the edge that accepts it, the
// token then walks the row of 64 cells one cell per cycle, and the result is
// registered behind the last cell. busy stays high until that result is put
// out, so no new transaction is taken while the draw is in flight. A draw on
// an incomplete table or a zero total puts its result out the cycle after it
// is accepted and leaves busy low. The receiver cannot stall: the result sits
// on rsp_payload for one cycle with rsp_valid and must be taken then.
`default_nettype none

module roulette_wheel_selector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire rws_pkg::request_type          req_payload,
   output logic                               rsp_valid,
   output rws_pkg::response_type              rsp_payload,
   input  wire logic                          csr_write_enable,
   input  wire logic [rws_pkg::SIZE_BITS-1:0] csr_write_data
);
   import rws_pkg::*;

   typedef enum logic [1:0] {IDLE, MULTIPLY, WALK} state_type;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   response_type            rsp_ff, rsp_in;
   logic [SIZE_BITS-1:0]    size_ff;
   logic [SIZE_BITS-1:0]    position_ff, position_in;
   logic [SUM_BITS-1:0]     total_ff, total_in;
   logic                    complete_ff, complete_in;
   logic [PRODUCT_BITS-1:0] product_ff, product_in;

   logic [SIZE_BITS-1:0]       n_eff;
   logic [INDEX_BITS-1:0]      last_index;
   logic [SIZE_BITS-1:0]       position_eff;
   logic [SIZE_BITS-1:0]       position_next;
   logic [SUM_BITS-1:0]        load_sum;
   logic [DRAW_FIELD_BITS-1:0] draw_sat;
   logic                       accept;
   logic                       load_accept;
   token_type                  inject;
   token_type                  chain [MAX_POPULATION+1];

   assign accept      = start && !busy;
   assign load_accept = accept && (req_payload.kind == KIND_LOAD);

   always_comb begin
      if (size_ff < SIZE_BITS'(2)) begin
         n_eff = SIZE_BITS'(2);
      end else if (size_ff > SIZE_BITS'(MAX_POPULATION)) begin
         n_eff = SIZE_BITS'(MAX_POPULATION);
      end else begin
         n_eff = size_ff;
      end
   end

   assign last_index    = INDEX_BITS'(n_eff - SIZE_BITS'(1));
   assign position_eff  = (position_ff >= n_eff) ? '0 : position_ff;
   assign position_next = position_eff + SIZE_BITS'(1);
   assign load_sum      = (position_eff == '0) ? SUM_BITS'(req_payload.fitness_value)
                          : total_ff + SUM_BITS'(req_payload.fitness_value);
   assign draw_sat      = (req_payload.draw_fraction > DRAW_FIELD_BITS'(1 << DRAW_BITS))
                          ? DRAW_FIELD_BITS'(1 << DRAW_BITS) : req_payload.draw_fraction;
   assign product_in    = PRODUCT_BITS'(total_ff) * PRODUCT_BITS'(draw_sat);

   always_comb begin
      inject.valid = (state_ff == MULTIPLY);
      inject.found = 1'b0;
      inject.index = '0;
   end

   assign chain[0] = inject;

   for (genvar i = 0; i < MAX_POPULATION; i++) begin : g_cell
      rws_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .write_enable (load_accept && (position_eff == SIZE_BITS'(i))),
         .write_data   (load_sum),
         .cell_index   (INDEX_BITS'(i)),
         .last_index   (last_index),
         .product      (product_ff),
         .token_i      (chain[i]),
         .token_o      (chain[i+1])
      );
   end

   always_comb begin
      state_in           = state_ff;
      rsp_valid_in       = 1'b0;
      rsp_in             = rsp_ff;
      position_in        = position_ff;
      total_in           = total_ff;
      complete_in        = complete_ff;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               if (req_payload.kind == KIND_LOAD) begin
                  total_in = load_sum;
                  if (position_next >= n_eff) begin
                     position_in = '0;
                     complete_in = 1'b1;
                  end else begin
                     position_in = position_next;
                     if (position_eff == '0) begin
                        complete_in = 1'b0;
                     end
                  end
               end else if (!complete_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.selected_index = '0;
                  rsp_in.status         = STATUS_INCOMPLETE;
               end else if (total_ff == '0) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.selected_index = '0;
                  rsp_in.status         = STATUS_ZERO_TOTAL;
               end else begin
                  state_in = MULTIPLY;
               end
            end
         end
         MULTIPLY: begin
            state_in = WALK;
         end
         WALK: begin
            if (chain[MAX_POPULATION].valid) begin
               state_in              = IDLE;
               rsp_valid_in          = 1'b1;
               rsp_in.selected_index = chain[MAX_POPULATION].index;
               rsp_in.status         = STATUS_OK;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      if (csr_write_enable) begin
         position_in = '0;
         total_in    = '0;
         complete_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_BITS'(MAX_POPULATION);
         position_ff  <= '0;
         total_ff     <= '0;
         complete_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         position_ff  <= position_in;
         total_ff     <= total_in;
         complete_ff  <= complete_in;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         product_ff <= product_in;
      end
   end

   assign busy        = (state_ff != IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/rws_cell.sv @@
// ----------------------------------------------------------------------------
// rws_cell
// One wheel slot: holds a prefix sum and tests the passing draw token.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_cell (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             write_enable,
   input  wire logic [rws_pkg::SUM_BITS-1:0]     write_data,
   input  wire logic [rws_pkg::INDEX_BITS-1:0]   cell_index,
   input  wire logic [rws_pkg::INDEX_BITS-1:0]   last_index,
   input  wire logic [rws_pkg::PRODUCT_BITS-1:0] product,
   input  wire rws_pkg::token_type               token_i,
   output rws_pkg::token_type                    token_o
);
   import rws_pkg::*;

   logic [SUM_BITS-1:0]     prefix_ff;
   logic [PRODUCT_BITS-1:0] scaled;
   logic                    hit;
   token_type               token_ff;
   token_type               token_in;

   assign scaled = PRODUCT_BITS'({prefix_ff, {DRAW_BITS{1'b0}}});
   assign hit    = token_i.valid && !token_i.found &&
                   ((cell_index == last_index) || (product <= scaled));

   always_comb begin
      token_in.valid = token_i.valid;
      token_in.found = token_i.found || hit;
      token_in.index = hit ? cell_index : token_i.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in.valid;
      end
      token_ff.found <= token_in.found;
      token_ff.index <= token_in.index;
      if (write_enable) begin
         prefix_ff <= write_data;
      end
   end

   assign token_o = token_ff;

endmodule

`default_nettype wire

@@ tb/roulette_wheel_selector_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector_test
// Self-checking bench for the fitness-proportional selector.
// ----------------------------------------------------------------------------
// A short table of directed steps covers reset, size saturation, zero totals,
// partial loads, boundary draws and oversized draw points. Random populations
// follow: full loads with varied fitness shapes, draws aimed at the wheel
// boundaries, broken loads and raw noise. Each accepted transaction runs
// through a local selection predictor; results are checked in order.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_test;
   import rws_pkg::*;

   localparam int TOTAL_ITEMS   = 1050;
   localparam int TAIL_ITEMS    = 150;
   localparam int SETTLE_CYCLES = MAX_POPULATION + 6;
   localparam int IDLE_LIMIT    = 1000;
   localparam int STEP_COUNT    = 26;

   typedef enum logic [1:0] {STEP_SIZE, STEP_LOAD, STEP_DRAW} step_kind_type;

   typedef struct packed {
      step_kind_type act;
      logic [31:0]   value;
      logic          pinned;
      response_type  result;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   request_type          req_payload = '0;
   logic                 rsp_valid;
   response_type         rsp_payload;
   logic                 csr_write_enable = 1'b0;
   logic [SIZE_BITS-1:0] csr_write_data = '0;

   // selection predictor state
   logic [SUM_BITS-1:0]  wheel_prefix [MAX_POPULATION];
   logic [SUM_BITS-1:0]  wheel_total = '0;
   int                   load_slot = 0;
   bit                   wheel_full = 1'b0;
   logic [SIZE_BITS-1:0] size_reg = 7'd64;

   response_type         pending_selections [$];
   bit                   pin_valid = 1'b0;
   response_type         pin_result = '0;
   bit                   idle_enabled = 1'b1;
   int                   items_sent = 0;
   int                   mismatches = 0;
   int                   idle_cycles = 0;
   step_row_type         directed_steps [STEP_COUNT];

   roulette_wheel_selector u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int size_in_use();
      int n;
      n = int'(size_reg);
      if (n < 2) n = 2;
      if (n > MAX_POPULATION) n = MAX_POPULATION;
      return n;
   endfunction

   function automatic request_type make_request(input logic kind, input logic [31:0] fit,
                                                input logic [DRAW_FIELD_BITS-1:0] point);
      request_type t;
      t.kind          = kind;
      t.fitness_value = fit;
      t.draw_fraction = point;
      return t;
   endfunction

   // Applies one transaction to the wheel state; returns 1 when it yields a result.
   function automatic bit select_for(input request_type t, output response_type r);
      int                       n;
      int                       sel;
      bit                       found;
      logic [DRAW_FIELD_BITS-1:0] point;
      logic [PRODUCT_BITS-1:0]  scaled_point;
      logic [PRODUCT_BITS-1:0]  bound;
      n = size_in_use();
      r = '0;
      if (t.kind == KIND_LOAD) begin
         if (load_slot >= n) load_slot = 0;
         if (load_slot == 0) begin
            wheel_total = '0;
            wheel_full  = 1'b0;
         end
         wheel_total = wheel_total + SUM_BITS'(t.fitness_value);
         wheel_prefix[load_slot] = wheel_total;
         load_slot++;
         if (load_slot >= n) begin
            load_slot  = 0;
            wheel_full = 1'b1;
         end
         return 1'b0;
      end
      if (!wheel_full) begin
         r.status = STATUS_INCOMPLETE;
         return 1'b1;
      end
      if (wheel_total == '0) begin
         r.status = STATUS_ZERO_TOTAL;
         return 1'b1;
      end
      point = t.draw_fraction;
      if (point > (1 << DRAW_BITS)) point = 1 << DRAW_BITS;
      scaled_point = PRODUCT_BITS'(wheel_total) * PRODUCT_BITS'(point);
      sel   = n - 1;
      found = 1'b0;
      for (int i = 0; i < n - 1; i++) begin
         bound = PRODUCT_BITS'(wheel_prefix[i]) << DRAW_BITS;
         if (!found && scaled_point <= bound) begin
            sel   = i;
            found = 1'b1;
         end
      end
      r.selected_index = INDEX_BITS'(sel);
      r.status         = STATUS_OK;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      response_type want;
      response_type got;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_selections.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, actual index %0d status %0d",
                        $time, rsp_payload.selected_index, rsp_payload.status);
            end else begin
               want = pending_selections.pop_front();
               if (rsp_payload.selected_index !== want.selected_index) begin
                  mismatches++;
                  $display("%0t: selected_index expected %0d actual %0d",
                           $time, want.selected_index, rsp_payload.selected_index);
               end
               if (rsp_payload.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_payload.status);
               end
            end
         end
         if (start && !busy) begin
            if (select_for(req_payload, got))
               pending_selections = {pending_selections, (pin_valid ? pin_result : got)};
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_item(input request_type t, input bit pinned, input response_type pin);
      int gap;
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         start = 1'b0;
         gap   = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      req_payload = t;
      pin_valid   = pinned;
      pin_result  = pin;
      start       = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic drain();
      start = 1'b0;
      while (pending_selections.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_BITS-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      size_reg    = value;
      load_slot   = 0;
      wheel_total = '0;
      wheel_full  = 1'b0;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin
      int          style;
      int          n;
      int          loads;
      int          pattern;
      int          v;
      logic [31:0] level;
      logic [31:0] fit;
      logic [DRAW_FIELD_BITS-1:0] point;
      logic [SIZE_BITS-1:0] sz;

      directed_steps = '{
         '{STEP_DRAW, 32'd0,          1'b1, '{6'd0, STATUS_INCOMPLETE}},
         '{STEP_SIZE, 32'd0,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'd0,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'd0,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd65536,      1'b1, '{6'd0, STATUS_ZERO_TOTAL}},
         '{STEP_LOAD, 32'd1,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd0,          1'b1, '{6'd0, STATUS_INCOMPLETE}},
         '{STEP_LOAD, 32'hFFFF_FFFF,  1'b0, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd0,          1'b1, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'h1_FFFF,     1'b1, '{6'd1, STATUS_OK}},
         '{STEP_DRAW, 32'd1,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_SIZE, 32'd3,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'hFFFF_FFFF,  1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'd0,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'hFFFF_FFFF,  1'b0, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd32768,      1'b1, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd32769,      1'b1, '{6'd2, STATUS_OK}},
         '{STEP_DRAW, 32'd65536,      1'b1, '{6'd2, STATUS_OK}},
         '{STEP_DRAW, 32'h1_5555,     1'b0, '{6'd0, STATUS_OK}},
         '{STEP_SIZE, 32'd127,        1'b0, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd65536,      1'b1, '{6'd0, STATUS_INCOMPLETE}},
         '{STEP_SIZE, 32'd1,          1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'h8000_0000,  1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'h7FFF_FFFF,  1'b0, '{6'd0, STATUS_OK}},
         '{STEP_DRAW, 32'd43690,      1'b0, '{6'd0, STATUS_OK}},
         '{STEP_LOAD, 32'h0001_0000,  1'b0, '{6'd0, STATUS_OK}}
      };

      repeat (11) @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         case (directed_steps[i].act)
            STEP_SIZE: write_size(directed_steps[i].value[SIZE_BITS-1:0]);
            STEP_LOAD: send_item(make_request(KIND_LOAD, directed_steps[i].value, '0),
                                 directed_steps[i].pinned, directed_steps[i].result);
            default:   send_item(make_request(KIND_DRAW, '0,
                                 directed_steps[i].value[DRAW_FIELD_BITS-1:0]),
                                 directed_steps[i].pinned, directed_steps[i].result);
         endcase
      end

      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0:       sz = 7'd0;
               1:       sz = 7'd1;
               2:       sz = 7'd2;
               3:       sz = 7'd64;
               4:       sz = SIZE_BITS'($urandom_range(65, 127));
               5:       sz = 7'd127;
               default: sz = SIZE_BITS'($urandom_range(2, 12));
            endcase
            write_size(sz);
         end
         idle_enabled = (items_sent < TOTAL_ITEMS - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) begin
            style = $urandom_range(0, 9);
            n     = size_in_use();
            if (style == 0) begin
               repeat ($urandom_range(1, 10))
                  send_item(make_request(1'($urandom), $urandom,
                            DRAW_FIELD_BITS'($urandom_range(0, 131071))), 1'b0, '0);
            end else begin
               // style 1 leaves the population partly loaded
               loads   = (style == 1) ? $urandom_range(1, n - 1) : n;
               pattern = $urandom_range(0, 4);
               level   = $urandom_range(1, 1 << 20);
               repeat (loads) begin
                  case (pattern)
                     0:       fit = $urandom;
                     1:       fit = '0;
                     2:       fit = level;
                     3:       fit = ($urandom_range(0, 5) == 0) ? $urandom : '0;
                     default: fit = 32'hFFFF_FFFF;
                  endcase
                  send_item(make_request(KIND_LOAD, fit, '0), 1'b0, '0);
               end
               repeat ($urandom_range(1, 6)) begin
                  case ($urandom_range(0, 7))
                     0: point = '0;
                     1: point = DRAW_FIELD_BITS'(65536);
                     2: point = DRAW_FIELD_BITS'($urandom_range(65537, 131071));
                     3, 4: begin
                        // land on or next to a slice boundary
                        v = (65536 * int'($urandom_range(1, n))) / n
                            + int'($urandom_range(0, 2)) - 1;
                        if (v < 0) v = 0;
                        point = DRAW_FIELD_BITS'(v);
                     end
                     default: point = DRAW_FIELD_BITS'($urandom_range(0, 65536));
                  endcase
                  send_item(make_request(KIND_DRAW, '0, point), 1'b0, '0);
               end
            end
            if ($urandom_range(0, 7) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
